/* design/fwt_pkg.sv */
// Shared types for the Fenwick frequency table: operation codes, controller states, control structs.
package fwt_pkg;

   // Operation codes carried in the request kind field
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_PREFIX = 2'd1,
      OP_RANGE  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_DONE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;     // latch a new request
      logic mem_rd;     // read node at current position
      logic add_wr;     // write node + delta, step position up
      logic sum_acc;    // fold node into accumulator, step position down
      logic next_phase; // range sum: start subtracting the lower prefix
      logic clr_wr;     // zero one node of the sweep
      logic load_rsp;   // move the result into the output register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      op_type op;
      logic   err;
      logic   reversed;
      logic   pos_zero;
      logic   pos_in_range;
      logic   phase;
      logic   sweep_last;
      logic   pending;
      logic   rsp_busy;
   } status_type;

endpackage

/* design/fenwick_frequency_table_unit.sv */
// Top level of the Fenwick frequency table: stream ports, controller and datapath.
//
// Binary indexed tree of 64-bit symbol frequencies with one node memory. Requests are
// taken one at a time and give one response each; a finished response waits in an output
// register while the next request is taken. Each node on a walk is read from the node
// memory, then written back with the delta added (add) or folded into the accumulator
// (prefix and range sums). An index error or a reversed range answers without a walk.
// Clear sweeps the node memory one entry a cycle; the same clearing pass runs after
// reset, with req_tready low throughout. symbol_count may be written only while idle and
// should be followed by a clear.
module fenwick_frequency_table_unit
   import fwt_pkg::*;
#(
   parameter int MAX_SYMBOLS = 256
) (
   input  logic        clock,
   input  logic        reset,
   // configuration: symbol_count
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // index_a[7:0], index_b[15:8], delta[79:16]
   input  logic [1:0]  req_tuser,  // operation[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // sum[63:0]
   output logic        rsp_tuser   // index_error[0]
);

   cmd_type    cmd;
   status_type status;
   op_type     req_op;

   assign req_op = op_type'(req_tuser);

   fwt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fwt_datapath #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_op          (req_op),
      .req_index_a     (req_tdata[7:0]),
      .req_index_b     (req_tdata[15:8]),
      .req_delta       (req_tdata[79:16]),
      .cmd             (cmd),
      .status          (status),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_sum         (rsp_tdata),
      .rsp_index_error (rsp_tuser)
   );

endmodule

/* design/fwt_datapath.sv */
// Datapath of the Fenwick frequency table: node memory, walk position, accumulator, output register.
module fwt_datapath
   import fwt_pkg::*;
#(
   parameter int MAX_SYMBOLS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata,
   input  op_type      req_op,
   input  logic [7:0]  req_index_a,
   input  logic [7:0]  req_index_b,
   input  logic [63:0] req_delta,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_sum,
   output logic        rsp_index_error
);

   localparam int AW   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int PosW = $clog2(MAX_SYMBOLS + 1) + 1;
   localparam int CW   = (PosW > 9) ? PosW : 9;

   logic [8:0]      symbol_count_ff;
   op_type          op_ff;
   logic [7:0]      index_a_ff;
   logic [63:0]     delta_ff;
   logic            err_ff, reversed_ff, pending_ff, phase_ff;
   logic [PosW-1:0] pos_ff, pos_in;
   logic [63:0]     acc_ff, acc_in;
   logic [AW-1:0]   sweep_ff;
   logic [63:0]     rdata_ff;
   logic [63:0]     mem [MAX_SYMBOLS];
   logic            rsp_valid_ff;
   logic [63:0]     rsp_sum_ff;
   logic            rsp_err_ff;

   logic [CW-1:0]   count_c, sc_c, a_c, b_c;
   logic [PosW-1:0] count_p, low_bit, node_p;
   logic [AW-1:0]   node_addr, wr_addr;
   logic            err_new;
   logic [63:0]     wr_data;
   logic            wr_en;

   // Effective symbol count, saturated to the node store depth
   always_comb begin
      sc_c    = CW'(symbol_count_ff);
      count_c = (sc_c > CW'(MAX_SYMBOLS)) ? CW'(MAX_SYMBOLS) : sc_c;
      count_p = PosW'(count_c);
      a_c     = CW'(req_index_a);
      b_c     = CW'(req_index_b);
   end

   // Index check at request time
   always_comb begin
      unique case (req_op) inside
         OP_ADD, OP_PREFIX: err_new = (a_c >= count_c);
         OP_RANGE:          err_new = (a_c >= count_c) || (b_c >= count_c);
         default:           err_new = 1'b0;
      endcase
   end

   // Walk position
   assign low_bit   = pos_ff & (~pos_ff + PosW'(1));
   assign node_p    = pos_ff - PosW'(1);
   assign node_addr = node_p[AW-1:0];

   always_comb begin
      pos_in = pos_ff;
      if (cmd.accept) begin
         if (req_op == OP_RANGE) pos_in = PosW'(b_c + CW'(1));
         else                    pos_in = PosW'(a_c + CW'(1));
      end else if (cmd.add_wr) begin
         pos_in = pos_ff + low_bit;
      end else if (cmd.sum_acc) begin
         pos_in = pos_ff - low_bit;
      end else if (cmd.next_phase) begin
         pos_in = PosW'(index_a_ff);
      end
   end

   // Accumulator: adds on the upper prefix, subtracts on the lower one
   always_comb begin
      acc_in = acc_ff;
      if (cmd.accept)       acc_in = '0;
      else if (cmd.sum_acc) acc_in = phase_ff ? (acc_ff - rdata_ff) : (acc_ff + rdata_ff);
   end

   // Request registers and control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= 9'd256;
         pending_ff      <= 1'b0;
         phase_ff        <= 1'b0;
         sweep_ff        <= '0;
      end else begin
         if (csr_we) symbol_count_ff <= csr_wdata;
         if (cmd.accept)        pending_ff <= 1'b1;
         else if (cmd.load_rsp) pending_ff <= 1'b0;
         if (cmd.accept)          phase_ff <= 1'b0;
         else if (cmd.next_phase) phase_ff <= 1'b1;
         if (cmd.accept)      sweep_ff <= '0;
         else if (cmd.clr_wr) sweep_ff <= sweep_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= req_op;
         index_a_ff  <= req_index_a;
         delta_ff    <= req_delta;
         err_ff      <= err_new;
         reversed_ff <= (req_index_b < req_index_a);
      end
      pos_ff <= pos_in;
      acc_ff <= acc_in;
   end

   // Node memory: one write port, one registered read port
   assign wr_en   = cmd.add_wr || cmd.clr_wr;
   assign wr_addr = cmd.clr_wr ? sweep_ff : node_addr;
   assign wr_data = cmd.clr_wr ? 64'd0 : (rdata_ff + delta_ff);

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.mem_rd) rdata_ff <= mem[node_addr];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_sum_ff <= acc_ff;
         rsp_err_ff <= err_ff;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_sum         = rsp_sum_ff;
   assign rsp_index_error = rsp_err_ff;

   // Status back to the controller
   always_comb begin
      status.op           = op_ff;
      status.err          = err_ff;
      status.reversed     = reversed_ff;
      status.pos_zero     = (pos_ff == '0);
      status.pos_in_range = (pos_ff <= count_p);
      status.phase        = phase_ff;
      status.sweep_last   = (sweep_ff == AW'(MAX_SYMBOLS - 1));
      status.pending      = pending_ff;
      status.rsp_busy     = rsp_valid_ff && !rsp_tready;
   end

endmodule

/* design/fwt_ctrl.sv */
// Controller of the Fenwick frequency table: sequences clears and tree walks.
module fwt_ctrl
   import fwt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.sweep_last) state_in = status.pending ? ST_DONE : ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (status.err || (status.op == OP_RANGE && status.reversed)) begin
               state_in = ST_DONE;
            end else begin
               unique case (status.op) inside
                  OP_CLEAR:            state_in = ST_CLEAR;
                  OP_ADD:              state_in = ST_ADD_RD;
                  OP_PREFIX, OP_RANGE: state_in = ST_SUM_RD;
                  default:             state_in = ST_DONE;
               endcase
            end
         end
         ST_ADD_RD: begin
            state_in = status.pos_in_range ? ST_ADD_WR : ST_DONE;
         end
         ST_ADD_WR: state_in = ST_ADD_RD;
         ST_SUM_RD: begin
            if (!status.pos_zero)                             state_in = ST_SUM_ACC;
            else if (!(status.op == OP_RANGE && !status.phase)) state_in = ST_DONE;
         end
         ST_SUM_ACC: state_in = ST_SUM_RD;
         ST_DONE: begin
            if (!status.rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_wr = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_ADD_RD: cmd.mem_rd = status.pos_in_range;
         ST_ADD_WR: cmd.add_wr = 1'b1;
         ST_SUM_RD: begin
            cmd.mem_rd     = !status.pos_zero;
            cmd.next_phase = status.pos_zero && status.op == OP_RANGE && !status.phase;
         end
         ST_SUM_ACC: cmd.sum_acc = 1'b1;
         ST_DONE: cmd.load_rsp = !status.rsp_busy;
         default: cmd = '0;
      endcase
   end

endmodule

/* dv/fwt_response_checker.sv */
`timescale 1ns / 100ps
// Checker for the Fenwick frequency table: mirrors the tree, predicts and compares each response.
module fwt_response_checker
   import fwt_pkg::*;
#(
   parameter int MAX_SYMBOLS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,  // index_a[7:0], index_b[15:8], delta[79:16]
   input  logic [1:0]  req_tuser,  // operation[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,  // sum[63:0]
   input  logic        rsp_tuser,  // index_error[0]
   output int          mismatch_count,
   output int          pending_count
);

   typedef struct packed {
      logic [63:0] sum;
      logic        index_error;
   } tree_answer_type;

   // Mirror of the node store, 1-based as in the tree walks
   logic [63:0]     node_freq [1:MAX_SYMBOLS];
   logic [8:0]      symbols_in_use;
   tree_answer_type awaited_answers[$];
   int              errors_seen;
   int              responses_seen;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      errors_seen    = 0;
      responses_seen = 0;
      symbols_in_use = 9'd256;
   end

   // Cumulative frequency of 1-based positions 1..pos
   function automatic logic [63:0] freq_through(int unsigned pos);
      logic [63:0] acc;
      acc = '0;
      while (pos > 0) begin
         acc += node_freq[pos];
         pos -= pos & (~pos + 1);
      end
      return acc;
   endfunction

   // Apply one request to the mirror and return the answer it should give
   function automatic tree_answer_type step_tree(op_type op, logic [7:0] a, logic [7:0] b,
                                                 logic [63:0] delta);
      tree_answer_type ans;
      int unsigned     active;
      int unsigned     pos;
      ans    = '0;
      active = (symbols_in_use > MAX_SYMBOLS) ? MAX_SYMBOLS : symbols_in_use;
      case (op)
         OP_ADD: begin
            if (a >= active) begin
               ans.index_error = 1'b1;
            end else begin
               pos = int'(a) + 1;
               while (pos <= active) begin
                  node_freq[pos] += delta;
                  pos += pos & (~pos + 1);
               end
            end
         end
         OP_PREFIX: begin
            if (a >= active) ans.index_error = 1'b1;
            else ans.sum = freq_through(int'(a) + 1);
         end
         OP_RANGE: begin
            if (a >= active || b >= active) ans.index_error = 1'b1;
            else if (b >= a) ans.sum = freq_through(int'(b) + 1) - freq_through(int'(a));
         end
         default: begin
            foreach (node_freq[k]) node_freq[k] = '0;
         end
      endcase
      return ans;
   endfunction

   task automatic note_mismatch(tree_answer_type want, logic has_want);
      errors_seen++;
      if (errors_seen <= 10) begin
         if (has_want)
            $display("%0t: response %0d: expected sum %h error %b, got sum %h error %b",
                     $time, responses_seen, want.sum, want.index_error, rsp_tdata, rsp_tuser);
         else
            $display("%0t: response %0d with no request outstanding: sum %h error %b",
                     $time, responses_seen, rsp_tdata, rsp_tuser);
      end
   endtask

   // Responses are checked before the request of the same edge is predicted
   always @(posedge clock) begin : watch_channels
      tree_answer_type want;
      if (reset) begin
         foreach (node_freq[k]) node_freq[k] = '0;
         symbols_in_use = 9'd256;
         awaited_answers.delete();
      end else begin
         if (csr_we) symbols_in_use = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            responses_seen++;
            if (awaited_answers.size() == 0) begin
               note_mismatch('0, 1'b0);
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_tdata !== want.sum || rsp_tuser !== want.index_error)
                  note_mismatch(want, 1'b1);
            end
         end
         if (req_tvalid && req_tready)
            awaited_answers.push_back(step_tree(op_type'(req_tuser), req_tdata[7:0],
                                                req_tdata[15:8], req_tdata[79:16]));
      end
      mismatch_count <= errors_seen;
      pending_count  <= awaited_answers.size();
   end

endmodule

/* dv/fenwick_frequency_table_unit_test.sv */
`timescale 1ns / 100ps
// Testbench top for the Fenwick frequency table: stimulus, response back-pressure and verdict.
module fenwick_frequency_table_unit_test;
   import fwt_pkg::*;

   localparam int MAX_SYMBOLS     = 256;
   localparam int STALL_LIMIT     = 3000;
   localparam int SETTLE_CYCLES   = 50;
   localparam int PHASE_REQUESTS  = 140;
   localparam int CHUNK_REQUESTS  = 35;
   localparam int PHASES          = 11;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [8:0]  csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = OP_ADD;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;

   int          mismatch_count;
   int          pending_count;
   int          idle_cycles     = 0;
   int          ready_hold      = 0;
   bit          sender_steady   = 1'b0;
   bit          receiver_steady = 1'b0;
   logic [8:0]  symbols_set     = 9'd256;

   // Settings per phase; a phase without a clear keeps the nodes of the one before
   int unsigned phase_count [PHASES] = '{256, 1, 2, 17, 511, 100, 256, 0, 255, 128, 256};
   bit          phase_clear [PHASES] = '{1, 1, 1, 1, 1, 0, 0, 0, 1, 1, 1};

   fenwick_frequency_table_unit #(.MAX_SYMBOLS(MAX_SYMBOLS)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   fwt_response_checker #(.MAX_SYMBOLS(MAX_SYMBOLS)) response_check (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response back-pressure: runs of ready and stall, mostly short
   always @(posedge clock) begin : rsp_ready_pattern
      int pick;
      pick = $urandom_range(0, 99);
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (receiver_steady) begin
         rsp_tready <= 1'b1;
      end else if (pick < 60) begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 4);
      end else if (pick < 92) begin
         rsp_tready <= 1'b0;
         ready_hold <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b0;
         ready_hold <= $urandom_range(8, 40);
      end
   end

   // Watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (sender_steady || pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Mostly in range, with the edges favoured and the odd index anywhere
   function automatic logic [7:0] pick_index(int unsigned active);
      int pick;
      pick = $urandom_range(0, 19);
      if (active == 0 || pick < 2) return 8'($urandom_range(0, 255));
      if (pick < 4) return 8'(active - 1);
      if (pick < 5) return 8'd0;
      return 8'($urandom_range(0, active - 1));
   endfunction

   function automatic logic [63:0] pick_delta();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return '1;
      if (pick == 1) return '0;
      if (pick == 2) return 64'h8000_0000_0000_0000;
      if (pick < 11) return 64'($urandom_range(1, 1000));
      return {$urandom, $urandom};
   endfunction

   // Present one request, hold it until taken, then maybe leave a gap
   task automatic send_request(op_type op, logic [7:0] a, logic [7:0] b, logic [63:0] delta);
      int gap;
      req_tdata  <= {delta, b, a};
      req_tuser  <= op;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sender holds off until every response is back, then lets the block settle
   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_symbol_count(logic [8:0] value);
      drain_and_settle();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we      <= 1'b0;
      symbols_set = value;
   endtask

   task automatic send_random_request();
      int unsigned active;
      int          pick;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  swap;
      op_type      op;
      active = (symbols_set > MAX_SYMBOLS) ? MAX_SYMBOLS : symbols_set;
      pick   = $urandom_range(0, 99);
      if (pick < 45) op = OP_ADD;
      else if (pick < 65) op = OP_PREFIX;
      else if (pick < 97) op = OP_RANGE;
      else op = OP_CLEAR;
      a = pick_index(active);
      b = pick_index(active);
      // most ranges are well ordered, some stay reversed
      if (op == OP_RANGE && a > b && $urandom_range(0, 4) != 0) begin
         swap = a;
         a    = b;
         b    = swap;
      end
      send_request(op, a, b, pick_delta());
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // wait out the clearing pass after reset
      @(posedge clock);
      while (!req_tready) @(posedge clock);

      // Directed: full table, wrap, extremes, single symbol, reversed range
      send_request(OP_ADD,    8'd0,   8'd0,   '1);
      send_request(OP_ADD,    8'd255, 8'd0,   64'd1);
      send_request(OP_ADD,    8'd128, 8'd7,   64'h8000_0000_0000_0000);
      send_request(OP_ADD,    8'd0,   8'd255, 64'd5);
      send_request(OP_PREFIX, 8'd0,   8'd0,   '0);
      send_request(OP_PREFIX, 8'd127, 8'd0,   '0);
      send_request(OP_PREFIX, 8'd255, 8'd255, '1);
      send_request(OP_RANGE,  8'd0,   8'd255, '0);
      send_request(OP_RANGE,  8'd128, 8'd128, '0);
      send_request(OP_RANGE,  8'd200, 8'd10,  '0);
      send_request(OP_RANGE,  8'd0,   8'd0,   '0);
      send_request(OP_CLEAR,  8'd0,   8'd0,   '0);
      send_request(OP_PREFIX, 8'd255, 8'd0,   '0);

      // Directed: out of range adds and sums, reversed span beyond the end
      write_symbol_count(9'd100);
      send_request(OP_CLEAR,  8'd0,   8'd0,   '0);
      send_request(OP_ADD,    8'd99,  8'd0,   64'd7);
      send_request(OP_ADD,    8'd100, 8'd0,   64'd3);
      send_request(OP_ADD,    8'd255, 8'd0,   64'd1);
      send_request(OP_PREFIX, 8'd99,  8'd0,   '0);
      send_request(OP_PREFIX, 8'd100, 8'd0,   '0);
      send_request(OP_RANGE,  8'd50,  8'd200, '0);
      send_request(OP_RANGE,  8'd200, 8'd50,  '0);
      send_request(OP_RANGE,  8'd99,  8'd99,  '0);

      // Directed: zero count flags every index
      write_symbol_count(9'd0);
      send_request(OP_ADD,    8'd0,   8'd0,   64'd1);
      send_request(OP_PREFIX, 8'd0,   8'd0,   '0);
      send_request(OP_RANGE,  8'd0,   8'd0,   '0);
      send_request(OP_CLEAR,  8'd0,   8'd0,   '0);

      // Random phases over the symbol count settings
      for (int phase = 0; phase < PHASES; phase++) begin
         write_symbol_count(9'(phase_count[phase]));
         if (phase_clear[phase]) send_request(OP_CLEAR, 8'd0, 8'd0, '0);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (n % CHUNK_REQUESTS == 0) begin
               case ((n / CHUNK_REQUESTS + phase) % 4)
                  0: begin
                     sender_steady   = 1'b0;
                     receiver_steady <= 1'b0;
                  end
                  1: begin
                     sender_steady   = 1'b1;
                     receiver_steady <= 1'b1;
                  end
                  2: begin
                     drain_and_settle();
                     sender_steady   = 1'b0;
                     receiver_steady <= 1'b1;
                  end
                  default: begin
                     sender_steady   = 1'b1;
                     receiver_steady <= 1'b0;
                  end
               endcase
            end
            send_random_request();
         end
      end

      drain_and_settle();
      if (mismatch_count == 0 && pending_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
